@@ design/arpse_pkg.sv @@
// Shared codes, widths and handshake structs of the arpeggiator step engine.
package arpse_pkg;

    localparam int RAND_W   = 15;
    localparam int CHORD_W  = 60;
    localparam int MASK_W   = 8;
    localparam int OCT_W    = 3;
    localparam int CMD_W    = 2;
    localparam int MODE_W   = 4;
    localparam int SPAN_W   = 3;
    localparam int DENS_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_HOLD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ARP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCT_SPAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_EN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_UP         = 4'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_UPDOWN     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_UPDOWN_REP = 4'd3;
    localparam logic [MODE_W-1:0] MODE_PED_UP     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_PED_DOWN   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_PED_UPDOWN = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE2   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_CHORD      = 4'd9;
    localparam logic [MODE_W-1:0] MODE_UP8        = 4'd10;
    localparam logic [MODE_W-1:0] MODE_DOWN8      = 4'd11;
    localparam logic [MODE_W-1:0] MODE_UPDOWN8    = 4'd12;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE8   = 4'd13;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE2_8 = 4'd14;

    localparam logic [DENS_W-1:0] DENSITY_RESET = 17'd65536;

    typedef struct packed {
        logic start;
        logic dir_down;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic wrap;
    } scan_rsp_t;

endpackage

@@ design/arpse_scan.sv @@
// String search unit: steps one string position per cycle up or down to the next available string.
module arpse_scan #(
    parameter int NUM_STRINGS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  arpse_pkg::scan_req_t           req,
    input  logic [NUM_STRINGS-1:0]         avail,
    input  logic                           from_vld,
    input  logic [$clog2(NUM_STRINGS)-1:0] from_idx,
    output arpse_pkg::scan_rsp_t           rsp,
    output logic                           res_vld,
    output logic [$clog2(NUM_STRINGS)-1:0] res_idx
);
    import arpse_pkg::*;

    localparam int SW = $clog2(NUM_STRINGS);
    localparam logic [SW-1:0] LAST = SW'(NUM_STRINGS - 1);

    logic          busy_reg;
    logic          dir_reg;
    logic [NUM_STRINGS-1:0] avail_reg;
    logic          prev_vld_reg;
    logic [SW-1:0] prev_idx_reg;
    logic          pos_vld_reg;
    logic [SW-1:0] pos_idx_reg;
    logic          done_reg;
    logic          wrap_reg;
    logic [SW-1:0] step_idx;
    logic          step_wrap;

    always_comb begin
        if (dir_reg) begin
            step_idx  = (!pos_vld_reg || pos_idx_reg == '0) ? LAST : pos_idx_reg - SW'(1);
            step_wrap = !prev_vld_reg || (prev_idx_reg <= step_idx);
        end else begin
            step_idx  = (!pos_vld_reg || pos_idx_reg == LAST) ? '0 : pos_idx_reg + SW'(1);
            step_wrap = prev_vld_reg && (prev_idx_reg >= step_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            wrap_reg     <= 1'b0;
            dir_reg      <= 1'b0;
            avail_reg    <= '0;
            prev_vld_reg <= 1'b0;
            prev_idx_reg <= '0;
            pos_vld_reg  <= 1'b0;
            pos_idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dir_reg      <= req.dir_down;
                avail_reg    <= avail;
                prev_vld_reg <= from_vld;
                prev_idx_reg <= from_idx;
                pos_vld_reg  <= from_vld;
                pos_idx_reg  <= from_idx;
                busy_reg     <= |avail;
                // no string to land on: finish at once, position held
                done_reg     <= ~|avail;
                wrap_reg     <= 1'b0;
            end else if (busy_reg) begin
                pos_vld_reg <= 1'b1;
                pos_idx_reg <= step_idx;
                if (avail_reg[step_idx]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    wrap_reg <= step_wrap;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.wrap = wrap_reg;
    assign res_vld  = pos_vld_reg;
    assign res_idx  = pos_idx_reg;

endmodule

@@ design/arpse_mod.sv @@
// Restoring remainder unit: one dividend bit per cycle against a small divisor.
module arpse_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [arpse_pkg::RAND_W-1:0]  dividend,
    input  logic [3:0]                    divisor,
    output logic                          done,
    output logic [3:0]                    rem
);
    import arpse_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [RAND_W-1:0] dvd_reg;
    logic [3:0]        div_reg;
    logic [3:0]        rem_reg;
    logic [4:0]        trial;
    logic [4:0]        diff;

    assign trial = {rem_reg, dvd_reg[RAND_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= (trial >= {1'b0, div_reg}) ? diff[3:0] : trial[3:0];
                dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(RAND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ design/arpeggiator_step_engine.sv @@
// Top level of the arpeggiator step engine: sequencer, state and streaming ports.
//
// Each request (hold tick, step or reset) gives exactly one result: the play mask, the
// trigger mask and the current octave offset. Hold ticks, resets, untouched requests and
// steps that do not advance go from acceptance straight to the done state, which loads the
// output register. An advancing step in the up, down and pedal modes runs the string search
// unit, which walks one string per cycle over a search of k positions (k from 1 to
// NUM_STRINGS). A bounce at the octave edge in an up/down mode adds one or two more
// searches. A pedal step that sounds the pending string, a chord step and a step in the
// unused mode code go straight to the finish state. Shuffle steps run the remainder unit
// two or three times (octave choice, first pick, second pick). The input side stays not
// ready until the result is loaded into the output register; that register lets the next
// request in while the result waits to be taken, so a stalled result holds up the next
// request only once that request reaches the done state.
module arpeggiator_step_engine #(
    parameter int NUM_STRINGS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [arpse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arpse_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // touch_mask[7:0], advance[8], play[9], rand_octave[24:10], rand_first[39:25],
    // rand_second[54:40], chord_rand_low[114:55], chord_rand_high[174:115], zero[175]
    input  logic [arpse_pkg::S_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [arpse_pkg::CMD_W-1:0]       s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // play_mask[7:0], trigger_mask[15:8], octave_offset[18:16], zero[23:19]
    output logic [arpse_pkg::M_DATA_W-1:0]    m_tdata
);
    import arpse_pkg::*;

    localparam int N  = NUM_STRINGS;
    localparam int SW = $clog2(NUM_STRINGS);
    localparam logic [N-1:0] ALL_STRINGS = {N{1'b1}};

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_KICK     = 4'd2;
    localparam logic [3:0] ST_WAIT     = 4'd3;
    localparam logic [3:0] ST_POST     = 4'd4;
    localparam logic [3:0] ST_OCT      = 4'd5;
    localparam logic [3:0] ST_PICK1    = 4'd6;
    localparam logic [3:0] ST_P2SET    = 4'd7;
    localparam logic [3:0] ST_PICK2    = 4'd8;
    localparam logic [3:0] ST_FIN      = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    function automatic logic [3:0] popcnt(input logic [N-1:0] m);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < N; i++) begin
            c = c + 4'(m[i]);
        end
        return c;
    endfunction

    // k-th lowest set bit of m as a one-hot mask
    function automatic logic [N-1:0] pick_bit(input logic [N-1:0] m, input logic [3:0] k);
        logic [3:0]   c;
        logic [N-1:0] r;
        c = '0;
        r = '0;
        for (int i = 0; i < N; i++) begin
            if (m[i] && c == k) begin
                r[i] = 1'b1;
            end
            c = c + 4'(m[i]);
        end
        return r;
    endfunction

    function automatic logic [N-1:0] onehot(input logic vld, input logic [SW-1:0] idx);
        return vld ? (N'(1) << idx) : '0;
    endfunction

    // configuration
    logic [MODE_W-1:0] mode_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              drop_reg;
    logic [DENS_W-1:0] dens_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UP;
            span_reg <= '0;
            drop_reg <= 1'b0;
            dens_reg <= DENSITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ARP_MODE: mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_OCT_SPAN: span_reg <= cfg_wr_data[SPAN_W-1:0];
                REG_DROP_EN:  drop_reg <= cfg_wr_data[0];
                REG_DENSITY:  dens_reg <= cfg_wr_data[DENS_W-1:0];
                default:      drop_reg <= drop_reg;
            endcase
        end
    end

    // arpeggiator state
    logic [3:0]        state_reg;
    logic [N-1:0]      held_reg;
    logic              cur_vld_reg;
    logic [SW-1:0]     cur_idx_reg;
    logic              down_reg;
    logic signed [3:0] oct_reg;
    logic              pend_vld_reg;
    logic [SW-1:0]     pend_idx_reg;
    logic [N-1:0]      used1_reg;
    logic [N-1:0]      used2_reg;

    // latched request
    logic [N-1:0]       touch_reg;
    logic               play_reg;
    logic [RAND_W-1:0]  ro_reg;
    logic [RAND_W-1:0]  r1_reg;
    logic [RAND_W-1:0]  r2_reg;
    logic [CHORD_W-1:0] chord_lo_reg;
    logic [CHORD_W-1:0] chord_hi_reg;

    // sequencer working registers
    logic         prim_down_reg;
    logic         scan_dir_reg;
    logic         bounce_reg;
    logic [1:0]   bnc_left_reg;
    logic [N-1:0] left_reg;
    logic [N-1:0] trig_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // octave window from the saturated span
    logic [2:0]        span_sat;
    logic signed [3:0] oct_top;
    logic signed [3:0] oct_bot;
    logic [3:0]        oct_range;

    always_comb begin
        span_sat = (span_reg > 3'd4) ? 3'd4 : span_reg;
        unique case (span_sat)
            3'd0:    oct_top = 4'sd0;
            3'd1:    oct_top = 4'sd1;
            3'd2:    oct_top = 4'sd1;
            default: oct_top = 4'sd2;
        endcase
        oct_bot   = oct_top - signed'({1'b0, span_sat});
        oct_range = {1'b0, span_sat} + 4'd1;
    end

    // mode decode
    logic         m_eight;
    logic         m_pedal;
    logic         m_shuffle;
    logic         m_shuf2;
    logic         m_bounce;
    logic         m_extra;
    logic [N-1:0] avail_c;
    logic [N-1:0] rest_c;
    logic [N-1:0] scan_avail;

    always_comb begin
        m_eight   = mode_reg >= MODE_UP8;
        m_pedal   = mode_reg == MODE_PED_UP || mode_reg == MODE_PED_DOWN
                    || mode_reg == MODE_PED_UPDOWN;
        m_shuffle = mode_reg == MODE_SHUFFLE || mode_reg == MODE_SHUFFLE2
                    || mode_reg == MODE_SHUFFLE8 || mode_reg == MODE_SHUFFLE2_8;
        m_shuf2   = mode_reg == MODE_SHUFFLE2 || mode_reg == MODE_SHUFFLE2_8;
        m_bounce  = mode_reg == MODE_UPDOWN || mode_reg == MODE_UPDOWN_REP
                    || mode_reg == MODE_PED_UPDOWN || mode_reg == MODE_UPDOWN8;
        m_extra   = mode_reg == MODE_UPDOWN || mode_reg == MODE_PED_UPDOWN;
        avail_c   = m_eight ? ALL_STRINGS : touch_reg;
        // pedal modes move over all but the lowest string, unless only one is touched
        rest_c    = avail_c & (avail_c - N'(1));
        if (rest_c == '0) begin
            rest_c = avail_c;
        end
        scan_avail = m_pedal ? rest_c : avail_c;
    end

    // shuffle candidate sets
    logic [N-1:0] left1_raw;
    logic [N-1:0] left1_c;
    logic [N-1:0] left2_raw;
    logic [N-1:0] left2_c;

    always_comb begin
        left1_raw = avail_c & ~used1_reg;
        left1_c   = (left1_raw == '0) ? avail_c : left1_raw;
        left2_raw = avail_c & ~used2_reg & ~held_reg;
        left2_c   = (left2_raw == '0) ? (avail_c & ~held_reg) : left2_raw;
    end

    // chord with random drops
    logic [N-1:0]  chord_c;
    logic [15:0]   chord_limit;
    logic [RAND_W-1:0] chord_r;

    always_comb begin
        chord_limit = dens_reg[DENS_W-1:1];
        chord_c     = avail_c;
        chord_r     = '0;
        for (int i = 0; i < N; i++) begin
            chord_r = (i < 4) ? chord_lo_reg[RAND_W*(i%4) +: RAND_W]
                              : chord_hi_reg[RAND_W*(i%4) +: RAND_W];
            if (drop_reg && ({1'b0, chord_r} >= chord_limit)) begin
                chord_c[i] = 1'b0;
            end
        end
    end

    // shared units
    scan_req_t      scan_req;
    scan_rsp_t      scan_rsp;
    logic           scan_res_vld;
    logic [SW-1:0]  scan_res_idx;
    logic              mod_start;
    logic [RAND_W-1:0] mod_dvd;
    logic [3:0]        mod_div;
    logic              mod_done;
    logic [3:0]        mod_rem;

    assign scan_req.start    = state_reg == ST_KICK;
    assign scan_req.dir_down = scan_dir_reg;

    arpse_scan #(
        .NUM_STRINGS(NUM_STRINGS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (scan_req),
        .avail    (scan_avail),
        .from_vld (cur_vld_reg),
        .from_idx (cur_idx_reg),
        .rsp      (scan_rsp),
        .res_vld  (scan_res_vld),
        .res_idx  (scan_res_idx)
    );

    always_comb begin
        mod_start = 1'b0;
        mod_dvd   = ro_reg;
        mod_div   = oct_range;
        priority if (state_reg == ST_DISPATCH && m_shuffle) begin
            mod_start = 1'b1;
        end else if (state_reg == ST_OCT && mod_done) begin
            mod_start = 1'b1;
            mod_dvd   = r1_reg;
            mod_div   = popcnt(left1_c);
        end else if (state_reg == ST_P2SET && left2_c != '0) begin
            mod_start = 1'b1;
            mod_dvd   = r2_reg;
            mod_div   = popcnt(left2_c);
        end else begin
            mod_start = 1'b0;
        end
    end

    arpse_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (mod_div),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    logic              s_acc;
    logic              out_free;
    logic signed [3:0] oct_up;
    logic signed [3:0] oct_dn;
    logic [N-1:0]      pick_c;

    assign s_tready = state_reg == ST_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign oct_up   = oct_reg + 4'sd1;
    assign oct_dn   = oct_reg - 4'sd1;
    assign pick_c   = pick_bit(left_reg, mod_rem);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            cur_vld_reg   <= 1'b0;
            cur_idx_reg   <= '0;
            down_reg      <= 1'b0;
            oct_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            used1_reg     <= '0;
            used2_reg     <= '0;
            prim_down_reg <= 1'b0;
            scan_dir_reg  <= 1'b0;
            bounce_reg    <= 1'b0;
            bnc_left_reg  <= '0;
            left_reg      <= '0;
            trig_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            touch_reg     <= '0;
            play_reg      <= 1'b0;
            ro_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            chord_lo_reg  <= '0;
            chord_hi_reg  <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        touch_reg    <= s_tdata[N-1:0];
                        play_reg     <= s_tdata[9];
                        ro_reg       <= s_tdata[24:10];
                        r1_reg       <= s_tdata[39:25];
                        r2_reg       <= s_tdata[54:40];
                        chord_lo_reg <= s_tdata[114:55];
                        chord_hi_reg <= s_tdata[174:115];
                        trig_reg     <= '0;
                        state_reg    <= ST_DONE;
                        priority if (s_tuser == CMD_RESET) begin
                            held_reg     <= '0;
                            cur_vld_reg  <= 1'b0;
                            down_reg     <= 1'b0;
                            oct_reg      <= '0;
                            pend_vld_reg <= 1'b0;
                            used1_reg    <= '0;
                            used2_reg    <= '0;
                        end else if (s_tdata[N-1:0] == '0) begin
                            held_reg <= '0;
                        end else if (s_tuser == CMD_STEP) begin
                            if (s_tdata[8]) begin
                                state_reg <= ST_DISPATCH;
                            end else if (!s_tdata[9]) begin
                                held_reg <= '0;
                            end
                        end else begin
                            held_reg <= held_reg;
                        end
                    end
                end
                ST_DISPATCH: begin
                    held_reg   <= '0;
                    bounce_reg <= 1'b0;
                    state_reg  <= ST_KICK;
                    priority if (m_pedal && pend_vld_reg && avail_c[pend_idx_reg]) begin
                        // pedal: sound the pending string, then move on next step
                        held_reg     <= onehot(1'b1, pend_idx_reg);
                        pend_vld_reg <= 1'b0;
                        state_reg    <= ST_FIN;
                    end else if (m_pedal) begin
                        prim_down_reg <= mode_reg == MODE_PED_DOWN
                                         || (mode_reg == MODE_PED_UPDOWN && down_reg);
                        scan_dir_reg  <= mode_reg == MODE_PED_DOWN
                                         || (mode_reg == MODE_PED_UPDOWN && down_reg);
                    end else if (m_shuffle) begin
                        state_reg <= ST_OCT;
                    end else if (mode_reg == MODE_CHORD) begin
                        held_reg  <= chord_c;
                        state_reg <= ST_FIN;
                    end else if (mode_reg == MODE_UP || mode_reg == MODE_UP8) begin
                        prim_down_reg <= 1'b0;
                        scan_dir_reg  <= 1'b0;
                    end else if (mode_reg == MODE_DOWN || mode_reg == MODE_DOWN8) begin
                        prim_down_reg <= 1'b1;
                        scan_dir_reg  <= 1'b1;
                    end else if (m_bounce) begin
                        prim_down_reg <= down_reg;
                        scan_dir_reg  <= down_reg;
                    end else begin
                        // unused mode code: empty step
                        state_reg <= ST_FIN;
                    end
                end
                ST_KICK: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (scan_rsp.done) begin
                        cur_vld_reg <= scan_res_vld;
                        cur_idx_reg <= scan_res_idx;
                        state_reg   <= ST_POST;
                        if (bounce_reg) begin
                            bnc_left_reg <= bnc_left_reg - 2'd1;
                            if (bnc_left_reg != 2'd1) begin
                                state_reg <= ST_KICK;
                            end
                        end else if (scan_rsp.wrap) begin
                            if (!prim_down_reg) begin
                                if (oct_up > oct_top) begin
                                    if (m_bounce) begin
                                        down_reg     <= 1'b1;
                                        oct_reg      <= oct_top;
                                        bounce_reg   <= 1'b1;
                                        scan_dir_reg <= 1'b1;
                                        bnc_left_reg <= m_extra ? 2'd2 : 2'd1;
                                        state_reg    <= ST_KICK;
                                    end else begin
                                        oct_reg <= oct_bot;
                                    end
                                end else begin
                                    oct_reg <= oct_up;
                                end
                            end else begin
                                if (oct_dn < oct_bot) begin
                                    if (m_bounce) begin
                                        down_reg     <= 1'b0;
                                        oct_reg      <= oct_bot;
                                        bounce_reg   <= 1'b1;
                                        scan_dir_reg <= 1'b0;
                                        bnc_left_reg <= m_extra ? 2'd2 : 2'd1;
                                        state_reg    <= ST_KICK;
                                    end else begin
                                        oct_reg <= oct_top;
                                    end
                                end else begin
                                    oct_reg <= oct_dn;
                                end
                            end
                        end
                    end
                end
                ST_POST: begin
                    if (m_pedal) begin
                        pend_vld_reg <= cur_vld_reg;
                        pend_idx_reg <= cur_idx_reg;
                        held_reg     <= avail_c ^ rest_c;
                    end else begin
                        held_reg <= onehot(cur_vld_reg, cur_idx_reg);
                    end
                    state_reg <= ST_FIN;
                end
                ST_OCT: begin
                    if (mod_done) begin
                        oct_reg  <= oct_bot + signed'({1'b0, mod_rem[2:0]});
                        left_reg <= left1_c;
                        if (left1_raw == '0) begin
                            used1_reg <= '0;
                        end
                        state_reg <= ST_PICK1;
                    end
                end
                ST_PICK1: begin
                    if (mod_done) begin
                        used1_reg <= used1_reg | pick_c;
                        held_reg  <= pick_c;
                        state_reg <= m_shuf2 ? ST_P2SET : ST_FIN;
                    end
                end
                ST_P2SET: begin
                    // second pick excludes the first one of this step
                    if (left2_raw == '0) begin
                        used2_reg <= '0;
                    end
                    left_reg  <= left2_c;
                    state_reg <= (left2_c != '0) ? ST_PICK2 : ST_FIN;
                end
                ST_PICK2: begin
                    if (mod_done) begin
                        used2_reg <= used2_reg | pick_c;
                        held_reg  <= held_reg | pick_c;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!play_reg) begin
                        held_reg <= '0;
                    end
                    trig_reg  <= play_reg ? held_reg : '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, oct_reg[OCT_W-1:0],
                                         MASK_W'(trig_reg), MASK_W'(held_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
